// ===== design/dense_layer_bias_relu_defines.svh =====
// Assertion macros shared by the dense layer RTL.
// Included by the top level; no other dependencies.
`ifndef DENSE_LAYER_BIAS_RELU_DEFINES_SVH
`define DENSE_LAYER_BIAS_RELU_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset
`define DLBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlbr: same-cycle check failed");
// Next-cycle implication
`define DLBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlbr: next-cycle check failed");
`else
`define DLBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DLBR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/dlbr_pkg.sv =====
// Shared constants, types and codes for the dense layer block.
// No dependencies; used by the interfaces, the top level and dlbr_cell.
`default_nettype none

package dlbr_pkg;

    // Layer geometry
    localparam int IN_FEATURES  = 512;
    localparam int OUT_FEATURES = 16;
    localparam int MAX_EMIT     = 16;

    // Payload widths (fixed by the word format)
    localparam int OP_W    = 2;
    localparam int FEAT_W  = 9;
    localparam int NIDX_W  = 4;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = 5;

    // Derived storage widths
    localparam int CELL_IDX_W = (OUT_FEATURES > 1) ? $clog2(OUT_FEATURES) : 1;
    localparam int WDEPTH     = IN_FEATURES * OUT_FEATURES;
    localparam int WADDR_W    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    // Register port
    localparam int NUM_CFG   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int PADDR_W   = CFG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    // Opcodes
    localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
    localparam logic [OP_W-1:0] OP_BIAS    = 2'd1;
    localparam logic [OP_W-1:0] OP_FEATURE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RELU  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

    // Reset values of the registers
    localparam logic             RELU_RST  = 1'b1;
    localparam logic [CNT_W-1:0] COUNT_RST = 5'd16;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Per-cell control
    typedef struct packed {
        logic               shift;
        logic               bias_we;
        logic [VALUE_W-1:0] bias_data;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/dlbr_in_if.sv =====
// Input channel of the dense layer block: load and feature words.
// Depends on dlbr_pkg for field widths.
`default_nettype none

interface dlbr_in_if;
    logic                              valid;
    logic                              ready;
    logic [dlbr_pkg::OP_W-1:0]         op;
    logic [dlbr_pkg::FEAT_W-1:0]       feat_index;
    logic [dlbr_pkg::NIDX_W-1:0]       out_index;
    logic signed [dlbr_pkg::VALUE_W-1:0] value;
    logic                              last;

    modport source (output valid, op, feat_index, out_index, value, last, input ready);
    modport sink   (input valid, op, feat_index, out_index, value, last, output ready);
endinterface

`default_nettype wire

// ===== design/dlbr_out_if.sv =====
// Result channel of the dense layer block: one neuron result per word.
// Depends on dlbr_pkg for field widths.
`default_nettype none

interface dlbr_out_if;
    logic                                valid;
    logic                                ready;
    logic [dlbr_pkg::NIDX_W-1:0]         neuron_index;
    logic signed [dlbr_pkg::VALUE_W-1:0] result_value;
    logic                                last_result;

    modport source (output valid, neuron_index, result_value, last_result, input ready);
    modport sink   (input valid, neuron_index, result_value, last_result, output ready);
endinterface

`default_nettype wire

// ===== design/dense_layer_bias_relu.sv =====
// Dense layer top: sequencer, weight RAM, multiplier and accumulator ring.
// Depends on dlbr_pkg, dlbr_in_if, dlbr_out_if, dlbr_ram, dlbr_cell
// and the assertion macros in dense_layer_bias_relu_defines.svh.
//
// Usage:
//  - feat_in carries one word per handshake: a weight load (op 0) writes
//    the weight RAM at (feat_index, out_index), a bias load (op 1) writes
//    the bias of neuron out_index, a feature word (op 2) multiplies value
//    by that feature's weight row and adds into the neuron sums.
//  - A load leaves the block idle, ready for the next word. A feature word
//    reads one weight per neuron (one read port), drains, then goes idle.
//  - After a feature word with last set, a pass rotates the ring once; the
//    first out_count positions (at least one, at most 16) leave on res_out,
//    and the sums refill with zeros.
//  - res_out is registered: a stall holds the word and pauses the ring;
//    the final word of a run may wait while feat_in takes the next word.
//  - relu_enable and out_count sit on the APB port (offsets 0x0, 0x4);
//    write them only while the block is idle.
//  - Reset clears the sums, sets relu_enable to 1 and out_count to 16;
//    weight RAM and biases hold nothing valid until loaded.
`default_nettype none
`include "dense_layer_bias_relu_defines.svh"

module dense_layer_bias_relu (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    dlbr_in_if.sink                            feat_in,
    dlbr_out_if.source                         res_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dlbr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [dlbr_pkg::PDATA_W-1:0]  pwdata,
    output      logic [dlbr_pkg::PDATA_W-1:0]  prdata,
    output      logic                          pready
);

    localparam int NCELL = dlbr_pkg::OUT_FEATURES;
    localparam int CIW   = dlbr_pkg::CELL_IDX_W;
    localparam int VW    = dlbr_pkg::VALUE_W;
    localparam int AW    = dlbr_pkg::WADDR_W;
    localparam int CW    = dlbr_pkg::CNT_W;

    // Configuration registers
    logic                              relu_reg;
    logic [CW-1:0]                     out_count_reg;
    logic [dlbr_pkg::CFG_IDX_W-1:0]    cfg_idx;
    logic                              cfg_wr;

    // Sequencer
    dlbr_pkg::state_t                  state_reg;
    dlbr_pkg::state_t                  state_next;
    logic [CIW-1:0]                    rd_cnt_reg;
    logic [CIW-1:0]                    rd_cnt_next;
    logic [CIW-1:0]                    em_cnt_reg;
    logic [CIW-1:0]                    em_cnt_next;
    logic                              in_rdy;
    logic                              emit_step;
    logic                              emit_live;
    logic                              emit_end;
    logic [CW-1:0]                     emit_n;

    // Feature word and datapath pipeline
    logic [VW-1:0]                     val_reg;
    logic [dlbr_pkg::FEAT_W-1:0]       feat_reg;
    logic                              last_reg;
    logic                              feat_ok;
    logic                              in_accept;
    logic                              rd_vld_reg;
    logic                              prod_vld_reg;
    logic [VW-1:0]                     prod_reg;
    logic [VW-1:0]                     mul_lo;
    logic [VW-1:0]                     ram_rdata;
    logic [AW-1:0]                     ram_waddr;
    logic [AW-1:0]                     ram_raddr;
    logic                              ram_we;
    logic                              ram_re;

    // Ring
    logic [VW-1:0]                     acc_q  [NCELL];
    logic [VW-1:0]                     bias_q [NCELL];
    dlbr_pkg::cell_ctrl_t              ctrl   [NCELL];
    logic [VW-1:0]                     tail_acc;
    logic [VW-1:0]                     tail_add;
    logic                              ring_shift;
    logic [VW-1:0]                     head_sum;
    logic [VW-1:0]                     head_res;

    // Output register
    logic                              out_vld_reg;
    logic [dlbr_pkg::NIDX_W-1:0]       out_nidx_reg;
    logic [VW-1:0]                     out_val_reg;
    logic                              out_last_reg;

    // ---------------------------------------------------------------
    // APB register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[dlbr_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relu_reg      <= dlbr_pkg::RELU_RST;
            out_count_reg <= dlbr_pkg::COUNT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                dlbr_pkg::CFG_RELU:  relu_reg      <= pwdata[0];
                dlbr_pkg::CFG_COUNT: out_count_reg <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            dlbr_pkg::CFG_RELU:  prdata = dlbr_pkg::PDATA_W'(relu_reg);
            dlbr_pkg::CFG_COUNT: prdata = dlbr_pkg::PDATA_W'(out_count_reg);
            default:             prdata = '0;
        endcase
    end

    // Results per run: out_count, at least one, at most the ring size
    always_comb
    begin
        emit_n = out_count_reg;
        if (emit_n == '0)
        begin
            emit_n = CW'(1);
        end
        if (int'(emit_n) > NCELL)
        begin
            emit_n = CW'(NCELL);
        end
        if (int'(emit_n) > dlbr_pkg::MAX_EMIT)
        begin
            emit_n = CW'(dlbr_pkg::MAX_EMIT);
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    assign feat_ok   = int'(feat_in.feat_index) < dlbr_pkg::IN_FEATURES;
    assign in_accept = feat_in.valid && in_rdy;
    assign feat_in.ready = in_rdy;
    assign emit_live = CW'(em_cnt_reg) < emit_n;
    assign emit_end  = int'(em_cnt_reg) == NCELL - 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dlbr_pkg::ST_IDLE;
            rd_cnt_reg <= '0;
            em_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            em_cnt_reg <= em_cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        em_cnt_next = em_cnt_reg;
        in_rdy      = 1'b0;
        emit_step   = 1'b0;
        unique case (state_reg)
            dlbr_pkg::ST_IDLE:
            begin
                in_rdy = 1'b1;
                if (feat_in.valid && feat_in.op == dlbr_pkg::OP_FEATURE)
                begin
                    if (feat_ok)
                    begin
                        state_next = dlbr_pkg::ST_READ;
                    end
                    else if (feat_in.last)
                    begin
                        state_next = dlbr_pkg::ST_EMIT;
                    end
                end
            end
            dlbr_pkg::ST_READ:
            begin
                if (int'(rd_cnt_reg) == NCELL - 1)
                begin
                    rd_cnt_next = '0;
                    state_next  = dlbr_pkg::ST_DRAIN;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + CIW'(1);
                end
            end
            dlbr_pkg::ST_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = last_reg ? dlbr_pkg::ST_EMIT : dlbr_pkg::ST_IDLE;
                end
            end
            dlbr_pkg::ST_EMIT:
            begin
                // positions past the run rotate without waiting on the sink
                emit_step = !emit_live || !out_vld_reg || res_out.ready;
                if (emit_step)
                begin
                    if (emit_end)
                    begin
                        em_cnt_next = '0;
                        state_next  = dlbr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        em_cnt_next = em_cnt_reg + CIW'(1);
                    end
                end
            end
            default:
            begin
                state_next = dlbr_pkg::ST_IDLE;
            end
        endcase
    end

    // Latch the feature word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
        end
        else if (in_accept && feat_in.op == dlbr_pkg::OP_FEATURE)
        begin
            last_reg <= feat_in.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && feat_in.op == dlbr_pkg::OP_FEATURE)
        begin
            val_reg  <= feat_in.value;
            feat_reg <= feat_in.feat_index;
        end
    end

    // ---------------------------------------------------------------
    // Weight RAM: row-major, one row of NCELL words per feature
    assign ram_we    = in_accept && feat_in.op == dlbr_pkg::OP_WEIGHT && feat_ok &&
                       int'(feat_in.out_index) < NCELL;
    assign ram_waddr = AW'(feat_in.feat_index) * AW'(NCELL) + AW'(feat_in.out_index);
    assign ram_re    = state_reg == dlbr_pkg::ST_READ;
    assign ram_raddr = AW'(feat_reg) * AW'(NCELL) + AW'(rd_cnt_reg);

    dlbr_ram #(
        .WIDTH (VW),
        .DEPTH (dlbr_pkg::WDEPTH)
    ) u_wram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (feat_in.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Multiply stage: low 32 bits of value * weight
    assign mul_lo = val_reg * ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= ram_re;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= mul_lo;
        end
    end

    // ---------------------------------------------------------------
    // Accumulator ring: cell 0 is the head, the tail takes head + product (zero while emitting)
    assign ring_shift = prod_vld_reg || emit_step;
    assign tail_acc   = (state_reg == dlbr_pkg::ST_EMIT) ? '0 : acc_q[0];
    assign tail_add   = (state_reg == dlbr_pkg::ST_EMIT) ? '0 : prod_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        logic [VW-1:0] nb_acc;
        logic [VW-1:0] nb_add;
        logic [VW-1:0] nb_bias;

        if (i == NCELL - 1)
        begin : g_tail
            assign nb_acc  = tail_acc;
            assign nb_add  = tail_add;
            assign nb_bias = bias_q[0];
        end
        else
        begin : g_body
            assign nb_acc  = acc_q[i+1];
            assign nb_add  = '0;
            assign nb_bias = bias_q[i+1];
        end

        assign ctrl[i].shift     = ring_shift;
        assign ctrl[i].bias_we   = in_accept && feat_in.op == dlbr_pkg::OP_BIAS &&
                                   int'(feat_in.out_index) == i;
        assign ctrl[i].bias_data = feat_in.value;

        dlbr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl[i]),
            .acc_in   (nb_acc),
            .add_in   (nb_add),
            .bias_in  (nb_bias),
            .acc_out  (acc_q[i]),
            .bias_out (bias_q[i])
        );
    end

    // Head result: sum plus bias, clamped when ReLU is on
    assign head_sum = acc_q[0] + bias_q[0];
    assign head_res = (relu_reg && head_sum[VW-1]) ? '0 : head_sum;

    // ---------------------------------------------------------------
    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (emit_step && emit_live)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_step && emit_live)
        begin
            out_nidx_reg <= dlbr_pkg::NIDX_W'(em_cnt_reg);
            out_val_reg  <= head_res;
            out_last_reg <= (CW'(em_cnt_reg) + CW'(1)) == emit_n;
        end
    end

    assign res_out.valid        = out_vld_reg;
    assign res_out.neuron_index = out_nidx_reg;
    assign res_out.result_value = out_val_reg;
    assign res_out.last_result  = out_last_reg;

    // ---------------------------------------------------------------
    // Checks
    `DLBR_ASSERT_IMP(a_idle_drained, clk, rst_n, in_rdy, !rd_vld_reg && !prod_vld_reg)
    `DLBR_ASSERT_IMP(a_prod_window, clk, rst_n, prod_vld_reg, state_reg == dlbr_pkg::ST_READ || state_reg == dlbr_pkg::ST_DRAIN)
    `DLBR_ASSERT_NXT(a_emit_loads, clk, rst_n, emit_step && emit_live, out_vld_reg)
    `DLBR_ASSERT_IMP(a_last_index, clk, rst_n, out_vld_reg && out_last_reg, (CW'(out_nidx_reg) + CW'(1)) == emit_n)

endmodule

`default_nettype wire

// ===== design/dlbr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dlbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output      logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/dlbr_cell.sv =====
// One cell of the accumulator ring: holds one neuron's sum and bias.
// Depends on dlbr_pkg for widths and the cell control struct.
`default_nettype none

module dlbr_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dlbr_pkg::cell_ctrl_t          ctrl,
    input  wire logic [dlbr_pkg::VALUE_W-1:0]  acc_in,
    input  wire logic [dlbr_pkg::VALUE_W-1:0]  add_in,
    input  wire logic [dlbr_pkg::VALUE_W-1:0]  bias_in,
    output      logic [dlbr_pkg::VALUE_W-1:0]  acc_out,
    output      logic [dlbr_pkg::VALUE_W-1:0]  bias_out
);

    logic [dlbr_pkg::VALUE_W-1:0] acc_reg;
    logic [dlbr_pkg::VALUE_W-1:0] acc_next;
    logic [dlbr_pkg::VALUE_W-1:0] bias_reg;
    logic [dlbr_pkg::VALUE_W-1:0] bias_next;

    // Take the neighbor's sum plus the incoming product on a shift
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.shift)
        begin
            acc_next = acc_in + add_in;
        end
    end

    // Bias rotates with the sum; a load writes it in place
    always_comb
    begin
        bias_next = bias_reg;
        if (ctrl.shift)
        begin
            bias_next = bias_in;
        end
        else if (ctrl.bias_we)
        begin
            bias_next = ctrl.bias_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bias_reg <= bias_next;
    end

    assign acc_out  = acc_reg;
    assign bias_out = bias_reg;

endmodule

`default_nettype wire
